// ----- rtl/tfs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_pkg - shared types and constants of the timed flush sequencer
// Step codes, register indexes, drain status codes and the structs that
// pass between the request tracker and the step sequencer.
// ----------------------------------------------------------------------------
package tfs_pkg;

	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned StepCntW = 16;
	localparam int unsigned TickCntW = 32;
	localparam int unsigned ReqW = 3;

	// register indexes on the configuration port
	localparam logic [CfgIdxW-1:0] CFG_STEP_DELAY = 3'd0;
	localparam logic [CfgIdxW-1:0] CFG_HOLD = 3'd1;
	localparam logic [CfgIdxW-1:0] CFG_DRAIN_FLUSH = 3'd2;
	localparam logic [CfgIdxW-1:0] CFG_IDLE_LIMIT = 3'd3;
	localparam logic [CfgIdxW-1:0] CFG_SINCE_LIMIT = 3'd4;

	// register reset values
	localparam logic [StepCntW-1:0] RST_STEP_DELAY = 16'd5;
	localparam logic [StepCntW-1:0] RST_HOLD = 16'd1800;
	localparam logic [StepCntW-1:0] RST_DRAIN_FLUSH = 16'd30;
	localparam logic [TickCntW-1:0] RST_IDLE_LIMIT = 32'd216000;
	localparam logic [TickCntW-1:0] RST_SINCE_LIMIT = 32'd864000;

	// fixed wait before the close command step
	localparam logic [StepCntW-1:0] CLOSE_WAIT_TICKS = 16'd20;

	// qualifying values of the caller off and on conditions
	localparam logic [7:0] OFF_QUALIFY = 8'h00;
	localparam logic [7:0] ON_QUALIFY = 8'h01;

	// drain motor status codes
	localparam logic [1:0] DRAIN_OPEN = 2'd1;
	localparam logic [1:0] DRAIN_CLOSED = 2'd2;

	// request flag bits
	localparam int unsigned REQ_POWER_ON = 0;
	localparam int unsigned REQ_IDLE = 1;
	localparam int unsigned REQ_PERIODIC = 2;

	typedef enum logic [3:0] {
		ST_PREP_A      = 4'd0,
		ST_PREP_B      = 4'd1,
		ST_PREP_C      = 4'd2,
		ST_HOLD        = 4'd3,
		ST_OPEN_WAIT   = 4'd4,
		ST_DRAIN_FLUSH = 4'd5,
		ST_CLOSE_DELAY = 4'd6,
		ST_CLOSE_CMD   = 4'd7,
		ST_CLOSE_WAIT  = 4'd8,
		ST_SETTLE      = 4'd9,
		ST_DONE        = 4'd10
	} step_t;

	typedef struct packed {
		logic [7:0] off_state;
		logic [7:0] on_state;
		logic       feed_valve_on;
		logic       other_flush_active;
		logic       filters_present;
		logic       tank_sterilize_active;
		logic       self_test_active;
		logic       acid_clean_active;
		logic [1:0] drain_status;
	} in_item_t;

	// request tracker to sequencer
	typedef struct packed {
		logic active;
		logic abort_hold;
	} req_ctl_t;

	// sequencer to request tracker and result
	typedef struct packed {
		logic running;
		logic done;
		logic open_cmd;
		logic close_cmd;
	} seq_stat_t;

endpackage
`default_nettype wire

// ----- rtl/timed_flush_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// timed_flush_sequencer - flush request tracker and timed valve sequencer
// Each item is one tick; every tick yields one result item with the step,
// status pulses and pending requests after that tick.
// ----------------------------------------------------------------------------
//
//  channel  handshake                   payload
//  -------  --------------------------  ---------------------------------------
//  in       in_valid / in_ready         off_state .. drain_status (one tick)
//  out      out_valid / out_ready       seq_step .. pending_requests
//  cfg      cfg_wr_en (no back-pressure) cfg_index, cfg_data
//
//  An accepted item is registered in the input register; the tick is
//  evaluated from there into the result register, from which its result is
//  offered. One item per cycle is sustained while results are taken: the
//  input stage refills in the cycle it empties into the result register. A
//  stalled result holds both stages; nothing is dropped. Reset clears the
//  counters, requests, step state and loads the register defaults.
//
`default_nettype none
module timed_flush_sequencer (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// tick channel
	input  wire logic                             in_valid,
	output logic                                  in_ready,
	input  wire logic [7:0]                       off_state,
	input  wire logic [7:0]                       on_state,
	input  wire logic                             feed_valve_on,
	input  wire logic                             other_flush_active,
	input  wire logic                             filters_present,
	input  wire logic                             tank_sterilize_active,
	input  wire logic                             self_test_active,
	input  wire logic                             acid_clean_active,
	input  wire logic [1:0]                       drain_status,
	// result channel
	output logic                                  out_valid,
	input  wire logic                             out_ready,
	output logic [3:0]                            seq_step,
	output logic                                  flush_running,
	output logic                                  flush_done,
	output logic                                  open_drain_cmd,
	output logic                                  close_drain_cmd,
	output logic [2:0]                            pending_requests,
	// configuration
	input  wire logic                             cfg_wr_en,
	input  wire logic [tfs_pkg::CfgIdxW-1:0]      cfg_index,
	input  wire logic [tfs_pkg::CfgDataW-1:0]     cfg_data
);
	import tfs_pkg::*;

	// configuration registers
	logic [StepCntW-1:0] step_delay_q;
	logic [StepCntW-1:0] hold_q;
	logic [StepCntW-1:0] drain_flush_q;
	logic [TickCntW-1:0] idle_limit_q;
	logic [TickCntW-1:0] since_limit_q;

	// input stage
	in_item_t item_s1;
	logic     valid_s1;

	// result stage
	logic        out_valid_q;
	logic [3:0]  seq_step_q;
	logic        running_q;
	logic        done_q;
	logic        open_q;
	logic        close_q;
	logic [2:0]  pending_q;

	logic        in_fire;
	logic        out_free;
	logic        fire;
	req_ctl_t    ctl;
	seq_stat_t   stat;
	step_t       step_next;
	logic [ReqW-1:0] pending_d;

	// the result register is free when empty or being emptied this cycle
	assign out_free = !out_valid_q || out_ready;
	assign fire = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;
	assign in_fire = in_valid && in_ready;

	// configuration writes; indexes past the list are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_delay_q <= RST_STEP_DELAY;
			hold_q <= RST_HOLD;
			drain_flush_q <= RST_DRAIN_FLUSH;
			idle_limit_q <= RST_IDLE_LIMIT;
			since_limit_q <= RST_SINCE_LIMIT;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_STEP_DELAY:  step_delay_q <= cfg_data[StepCntW-1:0];
				CFG_HOLD:        hold_q <= cfg_data[StepCntW-1:0];
				CFG_DRAIN_FLUSH: drain_flush_q <= cfg_data[StepCntW-1:0];
				CFG_IDLE_LIMIT:  idle_limit_q <= cfg_data[TickCntW-1:0];
				CFG_SINCE_LIMIT: since_limit_q <= cfg_data[TickCntW-1:0];
				default: begin
				end
			endcase
		end
	end

	// input stage: hold the tick until the evaluation can move it on
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1.off_state <= off_state;
			item_s1.on_state <= on_state;
			item_s1.feed_valve_on <= feed_valve_on;
			item_s1.other_flush_active <= other_flush_active;
			item_s1.filters_present <= filters_present;
			item_s1.tank_sterilize_active <= tank_sterilize_active;
			item_s1.self_test_active <= self_test_active;
			item_s1.acid_clean_active <= acid_clean_active;
			item_s1.drain_status <= drain_status;
		end
	end

	// request tracking: raise requests, latch the start on a new qualify
	tfs_req u_req (
		.clk         (clk),
		.arst_n      (arst_n),
		.fire        (fire),
		.item        (item_s1),
		.idle_limit  (idle_limit_q),
		.since_limit (since_limit_q),
		.seq_done    (stat.done),
		.ctl         (ctl),
		.pending     (pending_d)
	);

	// step sequencing: advance the valve sequence one tick
	tfs_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.ctl          (ctl),
		.drain_status (item_s1.drain_status),
		.step_delay   (step_delay_q),
		.hold         (hold_q),
		.drain_flush  (drain_flush_q),
		.stat         (stat),
		.step_next    (step_next)
	);

	// result stage: load on evaluation, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			seq_step_q <= 4'(step_next);
			running_q <= stat.running;
			done_q <= stat.done;
			open_q <= stat.open_cmd;
			close_q <= stat.close_cmd;
			pending_q <= pending_d;
		end
	end

	assign out_valid = out_valid_q;
	assign seq_step = seq_step_q;
	assign flush_running = running_q;
	assign flush_done = done_q;
	assign open_drain_cmd = open_q;
	assign close_drain_cmd = close_q;
	assign pending_requests = pending_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && done_q |-> pending_q == '0 && seq_step_q == 4'(ST_PREP_A))
		else $error("timed_flush_sequencer: completion left requests or a step");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(running_q && done_q))
		else $error("timed_flush_sequencer: running and done in one result");

endmodule
`default_nettype wire

// ----- rtl/tfs_req.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_req - flush request tracker
// Keeps the power-on, idle and periodic requests, the idle and since-flush
// counters, and the qualify edge detector that latches a sequence start.
// ----------------------------------------------------------------------------
module tfs_req (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            fire,
	input  wire tfs_pkg::in_item_t               item,
	input  wire logic [tfs_pkg::TickCntW-1:0]    idle_limit,
	input  wire logic [tfs_pkg::TickCntW-1:0]    since_limit,
	input  wire logic                            seq_done,
	output tfs_pkg::req_ctl_t                    ctl,
	output logic [tfs_pkg::ReqW-1:0]             pending
);
	import tfs_pkg::*;

	logic                power_on_seen_q;
	logic [ReqW-1:0]     flags_q;
	logic [TickCntW-1:0] idle_cnt_q;
	logic [TickCntW-1:0] since_cnt_q;
	logic                armed_q;
	logic                start_q;

	logic [ReqW-1:0]     flags_mid;
	logic [TickCntW-1:0] idle_inc;
	logic [TickCntW-1:0] idle_d;
	logic [TickCntW-1:0] since_inc;
	logic [TickCntW-1:0] since_d;
	logic                armed_d;
	logic                start_mid;
	logic                qualify;

	always_comb begin
		flags_mid = flags_q;
		// one-time power-on request, suppressed while another flush runs
		if (!power_on_seen_q) begin
			if (item.other_flush_active) begin
				flags_mid[REQ_POWER_ON] = 1'b0;
			end else begin
				flags_mid[REQ_POWER_ON] = 1'b1;
			end
		end

		idle_inc = item.feed_valve_on ? '0 : idle_cnt_q + 1'b1;
		idle_d = idle_inc;
		if (idle_inc >= idle_limit) begin
			idle_d = '0;
			flags_mid[REQ_IDLE] = 1'b1;
		end

		since_inc = since_cnt_q + 1'b1;
		since_d = since_inc;
		if (since_inc >= since_limit) begin
			since_d = '0;
			flags_mid[REQ_PERIODIC] = 1'b1;
		end

		qualify = (item.off_state == OFF_QUALIFY) && (item.on_state == ON_QUALIFY) &&
			!item.other_flush_active && item.filters_present &&
			!item.tank_sterilize_active && !item.self_test_active &&
			!item.acid_clean_active;

		armed_d = armed_q;
		start_mid = start_q;
		if (qualify) begin
			if (armed_q) begin
				armed_d = 1'b0;
				if (flags_mid != '0) begin
					start_mid = 1'b1;
				end
			end
		end else begin
			armed_d = 1'b1;
		end

		ctl.active = (flags_mid != '0) && start_mid;
		ctl.abort_hold = item.other_flush_active || !item.filters_present ||
			item.tank_sterilize_active;

		pending = seq_done ? '0 : flags_mid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_on_seen_q <= 1'b0;
			flags_q <= '0;
			idle_cnt_q <= '0;
			since_cnt_q <= '0;
			armed_q <= 1'b0;
			start_q <= 1'b0;
		end else if (fire) begin
			power_on_seen_q <= 1'b1;
			flags_q <= pending;
			idle_cnt_q <= idle_d;
			since_cnt_q <= seq_done ? '0 : since_d;
			armed_q <= armed_d;
			start_q <= seq_done ? 1'b0 : start_mid;
		end
	end

	// a start is only ever latched against a pending request
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && seq_done |-> flags_mid != '0)
		else $error("tfs_req: sequence finished with no request pending");

endmodule
`default_nettype wire

// ----- rtl/tfs_seq.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tfs_seq - timed valve step sequencer
// Flush sequence with a shared step counter; waits on drain
// status and jumps to the closing steps when an interlock drops in the hold.
// ----------------------------------------------------------------------------
module tfs_seq (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            fire,
	input  wire tfs_pkg::req_ctl_t               ctl,
	input  wire logic [1:0]                      drain_status,
	input  wire logic [tfs_pkg::StepCntW-1:0]    step_delay,
	input  wire logic [tfs_pkg::StepCntW-1:0]    hold,
	input  wire logic [tfs_pkg::StepCntW-1:0]    drain_flush,
	output tfs_pkg::seq_stat_t                   stat,
	output tfs_pkg::step_t                       step_next
);
	import tfs_pkg::*;

	step_t               step_q;
	step_t               step_d;
	logic [StepCntW-1:0] cnt_q;
	logic [StepCntW-1:0] cnt_d;
	logic [StepCntW-1:0] cnt_inc;
	logic [StepCntW-1:0] limit;
	logic                reach;
	step_t               step_adv;

	assign cnt_inc = cnt_q + 1'b1;
	assign reach = cnt_inc >= limit;
	assign step_adv = step_t'(4'(step_q + 4'd1));

	always_comb begin
		case (step_q)
			ST_HOLD:        limit = hold;
			ST_DRAIN_FLUSH: limit = drain_flush;
			ST_CLOSE_DELAY: limit = CLOSE_WAIT_TICKS;
			default:        limit = step_delay;
		endcase
	end

	always_comb begin
		step_d = step_q;
		cnt_d = cnt_q;
		stat = '0;
		if (ctl.active) begin
			case (step_q)
				ST_PREP_A, ST_PREP_B, ST_PREP_C, ST_SETTLE, ST_DRAIN_FLUSH,
				ST_CLOSE_DELAY: begin
					cnt_d = reach ? '0 : cnt_inc;
					step_d = reach ? step_adv : step_q;
				end
				ST_HOLD: begin
					if (reach) begin
						cnt_d = '0;
						step_d = step_adv;
						stat.open_cmd = 1'b1;
					end else if (ctl.abort_hold) begin
						// interlock lost: skip to the closing steps
						cnt_d = '0;
						step_d = ST_CLOSE_DELAY;
					end else begin
						cnt_d = cnt_inc;
					end
				end
				ST_CLOSE_CMD: begin
					cnt_d = reach ? '0 : cnt_inc;
					step_d = reach ? step_adv : step_q;
					stat.close_cmd = reach;
				end
				ST_OPEN_WAIT: begin
					if (drain_status == DRAIN_OPEN) begin
						cnt_d = '0;
						step_d = ST_DRAIN_FLUSH;
					end
				end
				ST_CLOSE_WAIT: begin
					if (drain_status == DRAIN_CLOSED) begin
						cnt_d = '0;
						step_d = ST_SETTLE;
					end
				end
				ST_DONE: begin
					cnt_d = '0;
					step_d = ST_PREP_A;
					stat.done = 1'b1;
				end
				default: begin
					// unused step code: restart without finishing
					cnt_d = '0;
					step_d = ST_PREP_A;
				end
			endcase
			stat.running = !stat.done;
		end else begin
			// no start: drop back to the first step, keep the count
			step_d = ST_PREP_A;
		end
		step_next = step_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_PREP_A;
			cnt_q <= '0;
		end else if (fire) begin
			step_q <= step_d;
			cnt_q <= cnt_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && stat.done |-> step_q == ST_DONE)
		else $error("tfs_seq: done outside the final step");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && stat.open_cmd |=> step_q == ST_OPEN_WAIT)
		else $error("tfs_seq: open command did not lead to the open wait");

	assert property (@(posedge clk) disable iff (!arst_n)
		fire && stat.close_cmd |-> step_q == ST_CLOSE_CMD && ctl.active)
		else $error("tfs_seq: close command outside its step");

endmodule
`default_nettype wire
